[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/core/smf_pkg.sv]
`timescale 1ns / 1ps

package smf_pkg;

   localparam int WINDOW   = 3;
   localparam int SAMPLE_W = 12;
   // wide enough for a count of 0..WINDOW; ranks use the same width
   localparam int CNT_W    = $clog2(WINDOW + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type sample_array_type [WINDOW];
   typedef logic [CNT_W-1:0] count_type;
   typedef count_type rank_array_type [WINDOW];

   typedef struct packed {
      logic shift;   // take the neighbor's sample
      logic drop;    // clear the held sample
   } cell_ctrl_type;

endpackage

[rtl/core/smf_cell.sv]
`timescale 1ns / 1ps

module smf_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  smf_pkg::cell_ctrl_type    ctrl,
   input  smf_pkg::count_type        cell_idx,
   input  smf_pkg::sample_type       prev_value,
   input  logic                      prev_valid,
   input  smf_pkg::sample_array_type all_values,
   input  logic [smf_pkg::WINDOW-1:0] all_valids,
   output smf_pkg::sample_type       value_out,
   output logic                      valid_out,
   output smf_pkg::count_type        rank_out
);

   smf_pkg::sample_type value_ff, value_in;
   logic                valid_ff, valid_in;
   logic [smf_pkg::WINDOW-1:0] beats;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = prev_value;
         valid_in = prev_valid;
      end else if (ctrl.drop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // rank = number of held samples ordered below this one; ties break on position
   always_comb begin
      for (int j = 0; j < smf_pkg::WINDOW; j++) begin
         beats[j] = all_valids[j] &&
                    ((all_values[j] < value_ff) ||
                     ((all_values[j] == value_ff) &&
                      (smf_pkg::CNT_W'(j) < cell_idx)));
      end
   end

   assign rank_out  = smf_pkg::CNT_W'($countones(beats));
   assign value_out = value_ff;
   assign valid_out = valid_ff;

endmodule

[rtl/core/smf_median.sv]
`timescale 1ns / 1ps

module smf_median (
   input  smf_pkg::sample_array_type  values,
   input  logic [smf_pkg::WINDOW-1:0] valids,
   input  smf_pkg::rank_array_type    ranks,
   output smf_pkg::sample_type        median,
   output logic                       median_valid
);

   smf_pkg::count_type count;
   smf_pkg::count_type lo_rank;
   smf_pkg::count_type hi_rank;
   smf_pkg::sample_type lo_value;
   smf_pkg::sample_type hi_value;
   logic signed [smf_pkg::SAMPLE_W:0] pair_sum;

   assign count   = smf_pkg::CNT_W'($countones(valids));
   assign lo_rank = smf_pkg::count_type'(count - smf_pkg::CNT_W'(1)) >> 1;
   assign hi_rank = count >> 1;

   // pick the middle sample(s); for an odd count both picks are the same
   always_comb begin
      lo_value = '0;
      hi_value = '0;
      for (int i = 0; i < smf_pkg::WINDOW; i++) begin
         if (valids[i] && (ranks[i] == lo_rank)) begin
            lo_value = lo_value | values[i];
         end
         if (valids[i] && (ranks[i] == hi_rank)) begin
            hi_value = hi_value | values[i];
         end
      end
   end

   assign pair_sum = {lo_value[smf_pkg::SAMPLE_W-1], lo_value} +
                     {hi_value[smf_pkg::SAMPLE_W-1], hi_value};

   assign median_valid = (count != '0);
   assign median       = median_valid ? pair_sum[smf_pkg::SAMPLE_W:1] : '0;

endmodule

[rtl/core/sliding_window_median_filter.sv]
`timescale 1ns / 1ps
// Flow: the accepting edge loads the cell row and sets the pending flag; the median
// moves into the output register once that register is empty or being drained, and
// rsp_tvalid rises with that load.
// Throughput: one request per cycle while rsp_tready stays high; with rsp_tready low
// the row and the output register hold two requests, then req_tready drops.
// Reset: clears cell valid flags (empty window) and handshake state; sample
// registers are not reset.

`include "assert_macros.svh"

module sliding_window_median_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample, [15:12] zero
   input  logic [0:0]  req_tuser,   // [0] sample_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] median, [15:12] zero
   output logic [0:0]  rsp_tuser    // [0] median_valid
);

   localparam int W = smf_pkg::WINDOW;

   logic pend_ff, pend_in;
   logic out_valid_ff, out_valid_in;
   smf_pkg::sample_type out_median_ff, out_median_in;
   logic out_mvalid_ff, out_mvalid_in;

   logic accept;
   logic move;
   smf_pkg::sample_type req_sample;

   smf_pkg::sample_array_type win_value;
   logic [W-1:0]              win_valid;
   smf_pkg::rank_array_type   win_rank;
   smf_pkg::cell_ctrl_type    cell_ctrl [W];

   smf_pkg::sample_type med_value;
   logic                med_valid;

   assign req_sample = req_tdata[smf_pkg::SAMPLE_W-1:0];

   // the row holds a median not yet moved out; move it before the row changes
   assign move       = pend_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || move;
   assign accept     = req_tvalid && req_tready;

   generate
      for (genvar i = 0; i < W; i++) begin : g_cell
         smf_pkg::sample_type prev_value;
         logic                prev_valid;

         if (i == 0) begin : g_head
            assign prev_value = req_sample;
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_value = win_value[i-1];
            assign prev_valid = win_valid[i-1];
         end

         assign cell_ctrl[i].shift = accept && req_tuser[0];
         // full window and a failed reading: drop the oldest only
         assign cell_ctrl[i].drop  = (i == W - 1) && accept && !req_tuser[0] &&
                                     win_valid[W-1];

         smf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .cell_idx   (smf_pkg::CNT_W'(i)),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .all_values (win_value),
            .all_valids (win_valid),
            .value_out  (win_value[i]),
            .valid_out  (win_valid[i]),
            .rank_out   (win_rank[i])
         );
      end
   endgenerate

   smf_median u_median (
      .values       (win_value),
      .valids       (win_valid),
      .ranks        (win_rank),
      .median       (med_value),
      .median_valid (med_valid)
   );

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (move) begin
         pend_in = 1'b0;
      end

      out_valid_in  = out_valid_ff;
      out_median_in = out_median_ff;
      out_mvalid_in = out_mvalid_ff;
      if (move) begin
         out_valid_in  = 1'b1;
         out_median_in = med_value;
         out_mvalid_in = med_valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_median_ff <= out_median_in;
      out_mvalid_ff <= out_mvalid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(16 - smf_pkg::SAMPLE_W){1'b0}}, out_median_ff};
   assign rsp_tuser  = out_mvalid_ff;

   // held samples always fill the row from the newest end without gaps
   `ASSERT_ALWAYS(a_row_packed, clock, reset, ((win_valid + W'(1)) & win_valid) == '0)

   // an accepted good reading lands in the head cell
   `ASSERT_NEXT(a_head_load, clock, reset, accept && req_tuser[0], win_valid[0] && (win_value[0] == $past(req_sample)))

   // an empty-window result carries a zero median
   `ASSERT_IMPLIES(a_empty_zero, clock, reset, out_valid_ff && !out_mvalid_ff, out_median_ff == '0)

endmodule

[verif/sliding_window_median_filter_tb.sv]
`timescale 1ns / 1ps

module sliding_window_median_filter_tb;

   typedef struct packed {
      smf_pkg::sample_type median;
      logic                median_valid;
   } median_result_type;

   class median_scoreboard;
      smf_pkg::sample_type held [smf_pkg::WINDOW];
      int                  held_count;
      median_result_type   expected_medians [$];
      int                  mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      // Median of the held samples; even counts take the floor of the middle pair.
      function median_result_type window_median();
         int                vals [smf_pkg::WINDOW];
         int                key;
         int                j;
         median_result_type res;
         res = '0;
         if (held_count == 0) return res;
         for (int i = 0; i < held_count; i++) vals[i] = int'(held[i]);
         for (int i = 1; i < held_count; i++) begin
            key = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > key) begin
               vals[j] = vals[j-1];
               j--;
            end
            vals[j] = key;
         end
         if (held_count % 2 == 1) begin
            res.median = smf_pkg::sample_type'(vals[held_count/2]);
         end else begin
            res.median = smf_pkg::sample_type'((vals[held_count/2-1] + vals[held_count/2]) >>> 1);
         end
         res.median_valid = 1'b1;
         return res;
      endfunction

      function void note_request(smf_pkg::sample_type sample, logic sample_ok);
         // drop the oldest when full, even for a failed reading
         if (held_count == smf_pkg::WINDOW) begin
            for (int i = 1; i < smf_pkg::WINDOW; i++) held[i-1] = held[i];
            held_count = smf_pkg::WINDOW - 1;
         end
         if (sample_ok) begin
            held[held_count] = sample;
            held_count++;
         end
         expected_medians = {expected_medians, window_median()};
      endfunction

      function void check_response(logic [15:0] data, logic [0:0] user);
         median_result_type want;
         if (expected_medians.size() == 0) begin
            report($sformatf("unexpected response data=%h user=%b", data, user));
            return;
         end
         want = expected_medians[0];
         expected_medians.delete(0);
         if (data[11:0] !== want.median) begin
            report($sformatf("median: expected %0d actual %0d",
                             want.median, $signed(data[11:0])));
         end
         if (user[0] !== want.median_valid) begin
            report($sformatf("median_valid: expected %b actual %b",
                             want.median_valid, user[0]));
         end
         if (data[15:12] !== 4'b0) begin
            report($sformatf("tdata padding: expected 0 actual %h", data[15:12]));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] sample, [15:12] zero
   logic [0:0]  req_tuser;   // [0] sample_valid
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [11:0] median, [15:12] zero
   logic [0:0]  rsp_tuser;   // [0] median_valid

   median_scoreboard board = new();
   bit               hold_off_req = 1'b0;

   sliding_window_median_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   localparam int N_DIRECTED = 22;
   int dir_value [N_DIRECTED] = '{2047, -2048, 2047, 0, 100, -3, 0, -5, -1, -1, 7,
                                  2047, 2047, 2047, -2048, -2048, -2048, -2048, 0,
                                  -2047, -1, 1};
   bit dir_ok    [N_DIRECTED] = '{0, 1, 1, 1, 0, 1, 0, 1, 1, 1, 1,
                                  1, 1, 1, 0, 1, 1, 1, 0,
                                  1, 0, 1};

   task automatic send_request(input smf_pkg::sample_type sample, input logic sample_ok);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, sample};
      req_tuser  <= sample_ok;
      do @(posedge clock); while (!req_tready);
      board.note_request(sample, sample_ok);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic smf_pkg::sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return $urandom_range(0, 1) ? smf_pkg::sample_type'(2047)
                                     : smf_pkg::sample_type'(-2048);
      end
      // cluster around zero to get ties and near-equal neighbors
      if (pick < 4) return smf_pkg::sample_type'(int'($urandom_range(0, 6)) - 3);
      return smf_pkg::sample_type'($urandom_range(0, 4095));
   endfunction

   task automatic send_random(input int count, input bit with_gaps);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && left > 0) begin
            send_request(random_sample(), $urandom_range(0, 99) < 85);
            burst--;
            left--;
         end
         if (with_gaps && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end
   endtask

   // response side: check every accepted response, stall in changing modes
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      int  phase;
      logic ready_next;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      phase = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = (phase % 4 == 0);
            default: ready_next = ($urandom_range(0, 9) == 0);
         endcase
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_request(smf_pkg::sample_type'(dir_value[i]), dir_ok[i]);
      end
      idle_sender(3);

      send_random(600, 1'b1);

      // stall the response side and keep pushing until the input backs up
      hold_off_req = 1'b1;
      send_random(40, 1'b0);

      send_random(500, 1'b1);

      // pause until every outstanding median has come back
      req_tvalid <= 1'b0;
      while (board.expected_medians.size() != 0) @(posedge clock);

      send_random(640, 1'b1);

      req_tvalid <= 1'b0;
      while (board.expected_medians.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.expected_medians.size() != 0) board.report("results left outstanding");

      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/smf_pkg.sv
rtl/core/smf_cell.sv
rtl/core/smf_median.sv
rtl/core/sliding_window_median_filter.sv
verif/sliding_window_median_filter_tb.sv
